// ===== hdl/hct_pkg.sv =====
// ----------------------------------------------------------------------------
// hct_pkg: shared types, constants and functions for the HSV color-type
// histogram.
// Widths, color-type codes, classification thresholds and the pixel
// classifier used by the histogram; the widths are shared with its divider.
// ----------------------------------------------------------------------------
package hct_pkg;

  // Frame size limit and derived widths.
  localparam int MaxPixelsLog2 = 20;
  localparam int CntW          = MaxPixelsLog2 + 1;
  localparam int NumTypes      = 11;
  localparam int TypeW         = 4;
  localparam int PctW          = 7;
  localparam int NumW          = CntW + PctW;
  localparam int StepW         = $clog2(PctW);
  localparam int InDataW       = 24;
  localparam int OutDataW      = 16;

  // Scale factor for percentages.
  localparam logic [PctW-1:0] PctScale = PctW'(100);

  // Color-type codes.
  localparam logic [TypeW-1:0] TypeBlack  = TypeW'(0);
  localparam logic [TypeW-1:0] TypeWhite  = TypeW'(1);
  localparam logic [TypeW-1:0] TypeGrey   = TypeW'(2);
  localparam logic [TypeW-1:0] TypeRed    = TypeW'(3);
  localparam logic [TypeW-1:0] TypeOrange = TypeW'(4);
  localparam logic [TypeW-1:0] TypeYellow = TypeW'(5);
  localparam logic [TypeW-1:0] TypeGreen  = TypeW'(6);
  localparam logic [TypeW-1:0] TypeAqua   = TypeW'(7);
  localparam logic [TypeW-1:0] TypeBlue   = TypeW'(8);
  localparam logic [TypeW-1:0] TypePurple = TypeW'(9);
  localparam logic [TypeW-1:0] TypePink   = TypeW'(10);

  // Classification thresholds.
  localparam logic [7:0] ValDark     = 8'd75;
  localparam logic [7:0] HueDark     = 8'd5;
  localparam logic [7:0] ValBright   = 8'd190;
  localparam logic [7:0] SatWhite    = 8'd27;
  localparam logic [7:0] SatGrey     = 8'd53;
  localparam logic [7:0] ValGrey     = 8'd185;
  localparam logic [7:0] HueRed      = 8'd18;
  localparam logic [7:0] HueOrange   = 8'd25;
  localparam logic [7:0] HueYellow   = 8'd34;
  localparam logic [7:0] HueGreen    = 8'd73;
  localparam logic [7:0] HueAqua     = 8'd102;
  localparam logic [7:0] HueBlue     = 8'd127;
  localparam logic [7:0] HuePurple   = 8'd149;
  localparam logic [7:0] HuePink     = 8'd175;

  // Sorts one pixel into its color type. Hues past the pink band wrap to red.
  function automatic logic [TypeW-1:0] classify(input logic [7:0] h,
                                                input logic [7:0] s,
                                                input logic [7:0] v);
    logic [TypeW-1:0] t;
    if (v < ValDark || h < HueDark)          t = TypeBlack;
    else if (v > ValBright && s < SatWhite)  t = TypeWhite;
    else if (s < SatGrey && v < ValGrey)     t = TypeGrey;
    else if (h < HueRed)                     t = TypeRed;
    else if (h < HueOrange)                  t = TypeOrange;
    else if (h < HueYellow)                  t = TypeYellow;
    else if (h < HueGreen)                   t = TypeGreen;
    else if (h < HueAqua)                    t = TypeAqua;
    else if (h < HueBlue)                    t = TypeBlue;
    else if (h < HuePurple)                  t = TypePurple;
    else if (h < HuePink)                    t = TypePink;
    else                                     t = TypeRed;
    return t;
  endfunction

  // Increment that sticks at all ones.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

endpackage

// ===== hdl/hct_div.sv =====
// ----------------------------------------------------------------------------
// hct_div: percentage divider.
// Restoring division of a scaled count by the pixel total, one quotient bit
// per cycle. The quotient is known to fit in PctW bits since count <= total.
// ----------------------------------------------------------------------------
module hct_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hct_pkg::NumW-1:0]  num_i,
  input  logic [hct_pkg::CntW-1:0]  den_i,
  output logic                      done_o,
  output logic [hct_pkg::PctW-1:0]  quo_o
);
  import hct_pkg::*;

  logic             run_q;
  logic [StepW-1:0] step_q;
  logic [NumW-1:0]  rem_q;
  logic [NumW-1:0]  dsr_q;
  logic [PctW-1:0]  quo_q;
  logic             done_q;
  logic             fit;

  // Current trial subtraction.
  assign fit = (rem_q >= dsr_q);

  // Iteration registers: the divisor starts at its top alignment and moves
  // down one bit per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == StepW'(PctW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + StepW'(1);
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsr_q <= NumW'(den_i) << (PctW - 1);
      quo_q <= '0;
    end else if (run_q) begin
      if (fit) rem_q <= rem_q - dsr_q;
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[PctW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/hsv_color_type_histogram.sv =====
// ----------------------------------------------------------------------------
// hsv_color_type_histogram: per-frame color-type histogram in percent.
// While counting, a pixel is taken every cycle; a pixel's count update is
// written to the count memory in the cycle after it is taken.
// Report: after the last pixel, a setup state, then eleven results, each made
// by a memory read, a divider load, 7 divider steps, done and output, the
// steps set by the bit-serial divider; a stalled output adds its wait.
// No pixel is taken during the report. Reset clears all counts at once.
// ----------------------------------------------------------------------------
module hsv_color_type_histogram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // [7:0] hue, [15:8] saturation, [23:16] value_level
  input  logic [hct_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,   // last_pixel
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] color_type, [10:4] percent, [15:11] zero
  output logic [hct_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,   // last_bin
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);
  import hct_pkg::*;

  typedef enum logic [2:0] {
    S_RUN, S_WAIT, S_READ, S_LOAD, S_DIV, S_OUT
  } state_e;

  state_e            state_q;
  logic [TypeW-1:0]  bin_q;
  logic [CntW-1:0]   total_q;
  logic [NumTypes-1:0] vld_q;

  // Count memory, one entry per color type.
  logic [CntW-1:0]   mem [NumTypes];
  logic [CntW-1:0]   rdata_q;
  logic [TypeW-1:0]  raddr;

  // Update pipeline.
  logic              s1_vld_q;
  logic [TypeW-1:0]  s1_type_q;
  logic              wr_vld_q;
  logic [TypeW-1:0]  wr_type_q;
  logic [CntW-1:0]   wr_data_q;
  logic [CntW-1:0]   cur_cnt;
  logic [CntW-1:0]   new_cnt;

  logic              in_acc;
  logic [TypeW-1:0]  in_type;
  logic [CntW-1:0]   rep_cnt;
  logic              div_start;
  logic              div_done;
  logic [PctW-1:0]   div_quo;
  logic [OutDataW-1:0] out_data_q;
  logic              out_last_q;
  logic              out_vld_q;

  assign s_axis_tready = (state_q == S_RUN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_type       = classify(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                  s_axis_tdata[23:16]);

  // Read address: the pixel's type while counting, the bin during a report.
  assign raddr = (state_q == S_RUN) ? in_type : bin_q;

  // Memory read and write.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) mem[s1_type_q] <= new_cnt;
    rdata_q <= mem[raddr];
  end

  // Current count: forwarded from the previous write to the same entry,
  // otherwise memory data, or zero for an entry not written this frame.
  always_comb begin
    if (wr_vld_q && wr_type_q == s1_type_q) cur_cnt = wr_data_q;
    else if (vld_q[s1_type_q])              cur_cnt = rdata_q;
    else                                    cur_cnt = '0;
    new_cnt = sat_inc(cur_cnt);
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
      wr_vld_q <= s1_vld_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_type_q <= in_type;
    wr_type_q <= s1_type_q;
    wr_data_q <= new_cnt;
  end

  // Report count of the current bin.
  assign rep_cnt   = vld_q[bin_q] ? rdata_q : '0;
  assign div_start = (state_q == S_LOAD);

  hct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NumW'(rep_cnt) * NumW'(PctScale)),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Report sequencer, valid bits, pixel total and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RUN;
      bin_q      <= '0;
      total_q    <= '0;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (s1_vld_q) vld_q[s1_type_q] <= 1'b1;
      unique case (state_q)
        S_RUN: begin
          if (in_acc) begin
            total_q <= sat_inc(total_q);
            if (s_axis_tlast) begin
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          bin_q   <= TypeBlack;
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_data_q <= OutDataW'({div_quo, bin_q});
            out_last_q <= (bin_q == TypePink);
            out_vld_q  <= 1'b1;
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_vld_q <= 1'b0;
            if (bin_q == TypePink) begin
              vld_q   <= '0;
              total_q <= '0;
              state_q <= S_RUN;
            end else begin
              bin_q   <= bin_q + TypeW'(1);
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_vld_q;

  // No pixel is taken while a report result is pending.
  a_no_in_during_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("pixel accepted during report");

  // The flagged result is the final color type.
  a_last_is_pink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[TypeW-1:0] == TypePink))
    else $error("last result on wrong color type");

  // A percentage never exceeds one hundred.
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TypeW+PctW-1:TypeW] <= PctScale))
    else $error("percent out of range");

  // After the final result is taken the counters are empty again.
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (total_q == '0 && vld_q == '0))
    else $error("counters not cleared after report");

endmodule
